@@ sv/gpio_pkg.sv @@
package gpio_pkg;

    localparam int WORD_W    = 32;
    localparam int HALF_PINS = 16;
    localparam int SEL_W     = 3;
    localparam int ACT_W     = 2;
    localparam int MODE_W    = 2;

    // s_axis_tdata layout
    localparam int IN_SEL_LSB    = 0;
    localparam int IN_WORD_LSB   = IN_SEL_LSB + SEL_W;
    localparam int IN_PADS_LSB   = IN_WORD_LSB + WORD_W;
    localparam int IN_USED_W     = IN_PADS_LSB + WORD_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // m_axis_tdata layout
    localparam int OUT_RD_LSB    = 0;
    localparam int OUT_DRIVE_LSB = OUT_RD_LSB + WORD_W;
    localparam int OUT_EN_LSB    = OUT_DRIVE_LSB + WORD_W;
    localparam int OUT_IRQ_LSB   = OUT_EN_LSB + WORD_W;
    localparam int OUT_USED_W    = OUT_IRQ_LSB + 2;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SAMPLE = 2'd2
    } t_action;

    typedef enum logic [SEL_W-1:0] {
        REG_DATA      = 3'd0,
        REG_DIR       = 3'd1,
        REG_PAD_STAT  = 3'd2,
        REG_ICR_LOW   = 3'd3,
        REG_ICR_HIGH  = 3'd4,
        REG_MASK      = 3'd5,
        REG_STATUS    = 3'd6,
        REG_EDGE_BOTH = 3'd7
    } t_reg_sel;

    localparam logic [MODE_W-1:0] MODE_LEVEL_LOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEVEL_HIGH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RISE       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FALL       = 2'd3;

    typedef struct packed {
        logic sample;
        logic clear;
    } t_stat_ctrl;

    typedef struct packed {
        logic high_pins;
        logic low_pins;
    } t_irq;

endpackage

@@ sv/gpio_lane.sv @@
module gpio_lane
    import gpio_pkg::*;
(
    input  logic              i_cur,
    input  logic              i_prev,
    input  logic              i_both,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_hit
);

    always_comb begin
        if (i_both) begin
            o_hit = i_cur ^ i_prev;
        end else begin
            case (i_mode)
                MODE_LEVEL_LOW:  o_hit = ~i_cur;
                MODE_LEVEL_HIGH: o_hit = i_cur;
                MODE_RISE:       o_hit = i_cur & ~i_prev;
                MODE_FALL:       o_hit = ~i_cur & i_prev;
                default:         o_hit = 1'b0;
            endcase
        end
    end

endmodule

@@ sv/gpio_merge.sv @@
module gpio_merge
    import gpio_pkg::*;
(
    input  logic [WORD_W-1:0] i_hits,
    input  logic [WORD_W-1:0] i_status,
    input  logic [WORD_W-1:0] i_clear_word,
    input  logic [WORD_W-1:0] i_mask_next,
    input  t_stat_ctrl        i_ctrl,
    output logic [WORD_W-1:0] o_status_next,
    output t_irq              o_irq
);

    logic [WORD_W-1:0] w_pend;

    always_comb begin
        if (i_ctrl.sample) begin
            o_status_next = i_status | i_hits;
        end else if (i_ctrl.clear) begin
            o_status_next = i_status & ~i_clear_word;
        end else begin
            o_status_next = i_status;
        end
        w_pend           = o_status_next & i_mask_next;
        o_irq.low_pins   = |w_pend[HALF_PINS-1:0];
        o_irq.high_pins  = |w_pend[WORD_W-1:HALF_PINS];
    end

endmodule

@@ sv/gpio_port_with_interrupts.sv @@
// gpio port with 32 pins, register map and edge/level interrupt detection
//
// input beats on s_axis: tuser carries the action (bus read, bus write or pad
// sample tick); tdata carries reg_select, write_word and pad_sample. every
// input beat gives exactly one output beat on m_axis carrying read_word (zero
// unless the beat was a read), the pad drive and enable words and the two
// interrupt lines, all taken after the beat's register update.
//
// one beat per cycle sustained while the receiver does not stall.
// each pin has its own detector lane working in the accept cycle; a merge
// stage folds the lane hits into the status word and the interrupt ors.
// results sit in an output register backed by a one-entry skid register, so
// input keeps flowing for one beat while the receiver stalls; s_axis_tready
// drops only once both hold a beat, and returns when the receiver takes one.
//
// synchronous active-low reset clears the register map (all pins inputs, all
// interrupts masked, no status, previous sample zero) and empties the output.
module gpio_port_with_interrupts
    import gpio_pkg::*;
#(
    parameter int PIN_COUNT = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] reg_select, [34:3] write_word, [66:35] pad_sample, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] read_word, [63:32] pad_drive, [95:64] pad_enable,
    // [96] irq_low_pins, [97] irq_high_pins, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [WORD_W-1:0] PinMask = {WORD_W{1'b1}} >> (WORD_W - PIN_COUNT);

    logic [WORD_W-1:0] r_data, n_data;
    logic [WORD_W-1:0] r_dir, n_dir;
    logic [WORD_W-1:0] r_mode_lo, n_mode_lo;
    logic [WORD_W-1:0] r_mode_hi, n_mode_hi;
    logic [WORD_W-1:0] r_mask, n_mask;
    logic [WORD_W-1:0] r_status, n_status;
    logic [WORD_W-1:0] r_edge_both, n_edge_both;
    logic [WORD_W-1:0] r_prev_pads, n_prev_pads;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_skid_valid;
    logic [OUT_TDATA_W-1:0] r_skid_data;

    logic                   w_accept;
    t_action                w_action;
    t_reg_sel               w_sel;
    logic [WORD_W-1:0]      w_word;
    logic [WORD_W-1:0]      w_pads;
    logic [WORD_W-1:0]      w_hits;
    logic [WORD_W-1:0]      w_read;
    logic                   w_wr;
    t_stat_ctrl             w_ctrl;
    t_irq                   w_irq;
    logic [OUT_TDATA_W-1:0] w_result;

    assign s_axis_tready = ~r_skid_valid;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_action      = t_action'(s_axis_tuser);
    assign w_sel         = t_reg_sel'(s_axis_tdata[IN_SEL_LSB +: SEL_W]);
    assign w_word        = s_axis_tdata[IN_WORD_LSB +: WORD_W];
    assign w_pads        = s_axis_tdata[IN_PADS_LSB +: WORD_W] & PinMask;
    assign w_wr          = (w_action == ACT_WRITE);

    // one detector lane per existing pin
    for (genvar p = 0; p < WORD_W; p++) begin : g_lane
        if (p < PIN_COUNT) begin : g_pin
            logic [MODE_W-1:0] w_mode;
            if (p < HALF_PINS) begin : g_lo
                assign w_mode = r_mode_lo[MODE_W*p +: MODE_W];
            end else begin : g_hi
                assign w_mode = r_mode_hi[MODE_W*(p-HALF_PINS) +: MODE_W];
            end
            gpio_lane u_lane (
                .i_cur  (w_pads[p]),
                .i_prev (r_prev_pads[p]),
                .i_both (r_edge_both[p]),
                .i_mode (w_mode),
                .o_hit  (w_hits[p])
            );
        end else begin : g_none
            assign w_hits[p] = 1'b0;
        end
    end

    always_comb begin
        n_data      = r_data;
        n_dir       = r_dir;
        n_mode_lo   = r_mode_lo;
        n_mode_hi   = r_mode_hi;
        n_mask      = r_mask;
        n_edge_both = r_edge_both;
        n_prev_pads = r_prev_pads;
        if (w_wr) begin
            unique case (w_sel)
                REG_DATA:      n_data      = w_word & PinMask;
                REG_DIR:       n_dir       = w_word & PinMask;
                REG_PAD_STAT:  ;
                REG_ICR_LOW:   n_mode_lo   = w_word;
                REG_ICR_HIGH:  n_mode_hi   = w_word;
                REG_MASK:      n_mask      = w_word & PinMask;
                REG_STATUS:    ;
                REG_EDGE_BOTH: n_edge_both = w_word & PinMask;
                default:       ;
            endcase
        end
        if (w_action == ACT_SAMPLE) begin
            n_prev_pads = w_pads;
        end
    end

    always_comb begin
        w_read = '0;
        if (w_action == ACT_READ) begin
            unique case (w_sel)
                REG_DATA:      w_read = r_data;
                REG_DIR:       w_read = r_dir;
                REG_PAD_STAT:  w_read = r_prev_pads;
                REG_ICR_LOW:   w_read = r_mode_lo;
                REG_ICR_HIGH:  w_read = r_mode_hi;
                REG_MASK:      w_read = r_mask;
                REG_STATUS:    w_read = r_status;
                REG_EDGE_BOTH: w_read = r_edge_both;
                default:       w_read = '0;
            endcase
        end
    end

    assign w_ctrl.sample = (w_action == ACT_SAMPLE);
    assign w_ctrl.clear  = w_wr && (w_sel == REG_STATUS);

    gpio_merge u_merge (
        .i_hits        (w_hits),
        .i_status      (r_status),
        .i_clear_word  (w_word),
        .i_mask_next   (n_mask),
        .i_ctrl        (w_ctrl),
        .o_status_next (n_status),
        .o_irq         (w_irq)
    );

    assign w_result = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                       w_irq.high_pins, w_irq.low_pins, n_dir, n_data, w_read};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data      <= '0;
            r_dir       <= '0;
            r_mode_lo   <= '0;
            r_mode_hi   <= '0;
            r_mask      <= '0;
            r_status    <= '0;
            r_edge_both <= '0;
            r_prev_pads <= '0;
        end else if (w_accept) begin
            r_data      <= n_data;
            r_dir       <= n_dir;
            r_mode_lo   <= n_mode_lo;
            r_mode_hi   <= n_mode_hi;
            r_mask      <= n_mask;
            r_status    <= n_status;
            r_edge_both <= n_edge_both;
            r_prev_pads <= n_prev_pads;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_data  <= w_result;
                r_skid_valid <= 1'b1;
            end else begin
                r_out_data  <= w_result;
                r_out_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ sv/gpio_checker.sv @@
module gpio_checker
    import gpio_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [ACT_W-1:0]       s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic w_in_beat;
    logic w_rd_data;
    logic w_rd_dir;

    assign w_in_beat = s_axis_tvalid && s_axis_tready;
    assign w_rd_data = (s_axis_tuser == ACT_READ) &&
                       (s_axis_tdata[IN_SEL_LSB +: SEL_W] == REG_DATA);
    assign w_rd_dir  = (s_axis_tuser == ACT_READ) &&
                       (s_axis_tdata[IN_SEL_LSB +: SEL_W] == REG_DIR);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat present after reset");

    // a stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // reading the data register returns what the pads are driven with
    a_rd_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && w_rd_data && !m_axis_tvalid |=>
            m_axis_tdata[OUT_RD_LSB +: WORD_W] == m_axis_tdata[OUT_DRIVE_LSB +: WORD_W])
        else $error("data read differs from pad drive");

    // reading the direction register returns the pad enables
    a_rd_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && w_rd_dir && !m_axis_tvalid |=>
            m_axis_tdata[OUT_RD_LSB +: WORD_W] == m_axis_tdata[OUT_EN_LSB +: WORD_W])
        else $error("direction read differs from pad enable");

endmodule

bind gpio_port_with_interrupts gpio_checker u_gpio_checker (.*);
